// File: src/lip_pkg.sv
// shared constants and types for the line crossing point block
package lip_pkg;

    localparam int QUOT_BITS = 33;
    localparam int OUT_W     = 32;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic none;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_flags;

endpackage

// File: src/lip_front.sv
// determinant front end: differences, cross products, magnitudes and divide set-up
module lip_front #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [COORD_BITS-1:0]         i_a_start_x,
    input  logic [COORD_BITS-1:0]         i_a_start_y,
    input  logic [COORD_BITS-1:0]         i_a_end_x,
    input  logic [COORD_BITS-1:0]         i_a_end_y,
    input  logic [COORD_BITS-1:0]         i_b_start_x,
    input  logic [COORD_BITS-1:0]         i_b_start_y,
    input  logic [COORD_BITS-1:0]         i_b_end_x,
    input  logic [COORD_BITS-1:0]         i_b_end_y,
    output logic                          o_valid,
    output logic [2*COORD_BITS:0]         o_dm,
    output logic [2*COORD_BITS:0]         o_rem_x,
    output logic [2*COORD_BITS:0]         o_rem_y,
    output logic [lip_pkg::QUOT_BITS-1:0] o_bits_x,
    output logic [lip_pkg::QUOT_BITS-1:0] o_bits_y,
    output lip_pkg::t_flags               o_flags
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * C;
    localparam int PDW  = 2 * C + 2;
    localparam int CW   = 2 * C + 1;
    localparam int NUMW = 3 * C + 2;
    localparam int NMW  = 3 * C + 1;
    localparam int DMW  = 2 * C + 1;
    localparam int QB   = lip_pkg::QUOT_BITS;
    localparam int SNW  = NMW + FRAC_BITS;
    localparam int NEXT = (SNW > QB) ? SNW : QB + 1;
    localparam int TW   = NEXT - QB;
    localparam int CMPW = ((TW > DMW) ? TW : DMW) + 1;

    // stage 1: differences and first products
    logic signed [DW-1:0]  s1_adx, s1_ady, s1_bdx, s1_bdy;
    logic signed [DW-1:0]  r1_adx, r1_ady, r1_bdx, r1_bdy;
    logic signed [PDW-1:0] r1_p1, r1_p2;
    logic [PW-1:0]         r1_q1, r1_q2, r1_q3, r1_q4;
    logic                  r1_valid;

    assign s1_adx = signed'({1'b0, i_a_start_x}) - signed'({1'b0, i_a_end_x});
    assign s1_ady = signed'({1'b0, i_a_start_y}) - signed'({1'b0, i_a_end_y});
    assign s1_bdx = signed'({1'b0, i_b_start_x}) - signed'({1'b0, i_b_end_x});
    assign s1_bdy = signed'({1'b0, i_b_start_y}) - signed'({1'b0, i_b_end_y});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_adx <= s1_adx;
            r1_ady <= s1_ady;
            r1_bdx <= s1_bdx;
            r1_bdy <= s1_bdy;
            r1_p1  <= PDW'(s1_adx) * PDW'(s1_bdy);
            r1_p2  <= PDW'(s1_ady) * PDW'(s1_bdx);
            r1_q1  <= PW'(i_a_start_x) * PW'(i_a_end_y);
            r1_q2  <= PW'(i_a_start_y) * PW'(i_a_end_x);
            r1_q3  <= PW'(i_b_start_x) * PW'(i_b_end_y);
            r1_q4  <= PW'(i_b_start_y) * PW'(i_b_end_x);
        end
    end

    // stage 2: denominator and line constants
    logic signed [DW-1:0]  r2_adx, r2_ady, r2_bdx, r2_bdy;
    logic signed [PDW-1:0] r2_den;
    logic signed [CW-1:0]  r2_ca, r2_cb;
    logic                  r2_valid;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_adx <= r1_adx;
            r2_ady <= r1_ady;
            r2_bdx <= r1_bdx;
            r2_bdy <= r1_bdy;
            r2_den <= r1_p1 - r1_p2;
            r2_ca  <= signed'({1'b0, r1_q1}) - signed'({1'b0, r1_q2});
            r2_cb  <= signed'({1'b0, r1_q3}) - signed'({1'b0, r1_q4});
        end
    end

    // stage 3: numerator products
    logic signed [PDW-1:0]  r3_den;
    logic signed [NUMW-1:0] r3_m1, r3_m2, r3_m3, r3_m4;
    logic                   r3_valid;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_den <= r2_den;
            r3_m1  <= NUMW'(r2_ca) * NUMW'(r2_bdx);
            r3_m2  <= NUMW'(r2_adx) * NUMW'(r2_cb);
            r3_m3  <= NUMW'(r2_ca) * NUMW'(r2_bdy);
            r3_m4  <= NUMW'(r2_ady) * NUMW'(r2_cb);
        end
    end

    // stage 4: numerators
    logic signed [PDW-1:0]  r4_den;
    logic signed [NUMW-1:0] r4_nx, r4_ny;
    logic                   r4_valid;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_den <= r3_den;
            r4_nx  <= r3_m1 - r3_m2;
            r4_ny  <= r3_m3 - r3_m4;
        end
    end

    // stage 5: magnitudes and signs
    logic [NUMW-1:0] s5_nx_abs, s5_ny_abs;
    logic [PDW-1:0]  s5_den_abs;
    logic [NMW-1:0]  r5_nm_x, r5_nm_y;
    logic [DMW-1:0]  r5_dm;
    logic            r5_neg_x, r5_neg_y, r5_none;
    logic            r5_valid;

    assign s5_nx_abs  = r4_nx[NUMW-1] ? NUMW'(-r4_nx) : NUMW'(r4_nx);
    assign s5_ny_abs  = r4_ny[NUMW-1] ? NUMW'(-r4_ny) : NUMW'(r4_ny);
    assign s5_den_abs = r4_den[PDW-1] ? PDW'(-r4_den) : PDW'(r4_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_nm_x  <= s5_nx_abs[NMW-1:0];
            r5_nm_y  <= s5_ny_abs[NMW-1:0];
            r5_dm    <= s5_den_abs[DMW-1:0];
            r5_neg_x <= r4_nx[NUMW-1] ^ r4_den[PDW-1];
            r5_neg_y <= r4_ny[NUMW-1] ^ r4_den[PDW-1];
            r5_none  <= (r4_den == '0);
        end
    end

    // stage 6: scale, range check of the top part, initial remainder
    logic [NEXT-1:0] s6_sn_x, s6_sn_y;
    logic [CMPW-1:0] s6_top_x, s6_top_y, s6_dm;

    assign s6_sn_x  = NEXT'(r5_nm_x) << FRAC_BITS;
    assign s6_sn_y  = NEXT'(r5_nm_y) << FRAC_BITS;
    assign s6_top_x = CMPW'(s6_sn_x[NEXT-1:QB]);
    assign s6_top_y = CMPW'(s6_sn_y[NEXT-1:QB]);
    assign s6_dm    = CMPW'(r5_dm);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dm          <= r5_dm;
            o_rem_x       <= s6_top_x[DMW-1:0];
            o_rem_y       <= s6_top_y[DMW-1:0];
            o_bits_x      <= s6_sn_x[QB-1:0];
            o_bits_y      <= s6_sn_y[QB-1:0];
            o_flags.none  <= r5_none;
            o_flags.neg_x <= r5_neg_x;
            o_flags.neg_y <= r5_neg_y;
            o_flags.ovf_x <= (s6_top_x >= s6_dm);
            o_flags.ovf_y <= (s6_top_y >= s6_dm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            o_valid  <= r5_valid;
        end
    end

endmodule

// File: src/lip_div_step.sv
// one restoring division step, one quotient bit for each coordinate
module lip_div_step #(
    parameter int DMW = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [DMW-1:0]                i_dm,
    input  logic [DMW-1:0]                i_rem_x,
    input  logic [DMW-1:0]                i_rem_y,
    input  logic [lip_pkg::QUOT_BITS-1:0] i_bits_x,
    input  logic [lip_pkg::QUOT_BITS-1:0] i_bits_y,
    input  lip_pkg::t_flags               i_flags,
    output logic                          o_valid,
    output logic [DMW-1:0]                o_dm,
    output logic [DMW-1:0]                o_rem_x,
    output logic [DMW-1:0]                o_rem_y,
    output logic [lip_pkg::QUOT_BITS-1:0] o_bits_x,
    output logic [lip_pkg::QUOT_BITS-1:0] o_bits_y,
    output lip_pkg::t_flags               o_flags
);

    localparam int QB = lip_pkg::QUOT_BITS;

    logic [DMW:0] s_dm, s_trial_x, s_trial_y, s_diff_x, s_diff_y;
    logic         s_ge_x, s_ge_y;

    assign s_dm      = {1'b0, i_dm};
    assign s_trial_x = {i_rem_x, i_bits_x[QB-1]};
    assign s_trial_y = {i_rem_y, i_bits_y[QB-1]};
    assign s_diff_x  = s_trial_x - s_dm;
    assign s_diff_y  = s_trial_y - s_dm;
    assign s_ge_x    = (s_trial_x >= s_dm);
    assign s_ge_y    = (s_trial_y >= s_dm);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dm     <= i_dm;
            o_rem_x  <= s_ge_x ? s_diff_x[DMW-1:0] : s_trial_x[DMW-1:0];
            o_rem_y  <= s_ge_y ? s_diff_y[DMW-1:0] : s_trial_y[DMW-1:0];
            o_bits_x <= {i_bits_x[QB-2:0], s_ge_x};
            o_bits_y <= {i_bits_y[QB-2:0], s_ge_y};
            o_flags  <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

endmodule

// File: src/lip_sat.sv
// sign restore, saturation and output register
module lip_sat (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [lip_pkg::QUOT_BITS-1:0]  i_quot_x,
    input  logic [lip_pkg::QUOT_BITS-1:0]  i_quot_y,
    input  lip_pkg::t_flags                i_flags,
    output logic                           o_valid,
    output logic signed [lip_pkg::OUT_W-1:0] o_cross_x,
    output logic signed [lip_pkg::OUT_W-1:0] o_cross_y,
    output logic                           o_no_crossing,
    output logic                           o_clipped
);

    localparam int W = lip_pkg::OUT_W;

    // returns {saturated, value}
    function automatic logic [W:0] lane_out(input logic [lip_pkg::QUOT_BITS-1:0] q,
                                            input logic neg, input logic ovf);
        logic big;
        logic [W-1:0] val;
        if (neg) begin
            big = ovf | q[W] | (q[W-1] & (|q[W-2:0]));
            val = big ? lip_pkg::OUT_MIN : W'(-q[W-1:0]);
        end else begin
            big = ovf | q[W] | q[W-1];
            val = big ? lip_pkg::OUT_MAX : q[W-1:0];
        end
        return {big, val};
    endfunction

    logic [W:0] s_x, s_y;

    assign s_x = lane_out(i_quot_x, i_flags.neg_x, i_flags.ovf_x);
    assign s_y = lane_out(i_quot_y, i_flags.neg_y, i_flags.ovf_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cross_x     <= i_flags.none ? '0 : signed'(s_x[W-1:0]);
            o_cross_y     <= i_flags.none ? '0 : signed'(s_y[W-1:0]);
            o_no_crossing <= i_flags.none;
            o_clipped     <= ~i_flags.none & (s_x[W] | s_y[W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

endmodule

// File: src/line_intersection_point_core.sv
// top level of the line crossing point pipeline
//
// Takes one pair of lines per beat on the input channel (i_in_valid / o_in_ready),
// each line as two unsigned pixel endpoints, and returns one beat on the output
// channel (o_out_valid / i_out_ready) with the crossing point in signed fixed
// point with FRAC_BITS fraction bits, a no-crossing flag for parallel or
// degenerate lines (coordinates zero) and a clipped flag when a coordinate
// saturates to the 32-bit range.
// The pipeline is six front stages (products, numerators, magnitudes), one
// stage per quotient bit of the 33-step restoring divider, and the saturating
// output register. Throughput is one beat per cycle unless the output stalls.
// The whole pipeline advances together: while the output register holds an
// untaken beat and i_out_ready is low, o_in_ready is low and every stage holds
// its contents, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; the block accepts
// beats from the first cycle after reset.
module line_intersection_point_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [COORD_BITS-1:0]            i_a_start_x,
    input  logic [COORD_BITS-1:0]            i_a_start_y,
    input  logic [COORD_BITS-1:0]            i_a_end_x,
    input  logic [COORD_BITS-1:0]            i_a_end_y,
    input  logic [COORD_BITS-1:0]            i_b_start_x,
    input  logic [COORD_BITS-1:0]            i_b_start_y,
    input  logic [COORD_BITS-1:0]            i_b_end_x,
    input  logic [COORD_BITS-1:0]            i_b_end_y,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [lip_pkg::OUT_W-1:0] o_cross_x,
    output logic signed [lip_pkg::OUT_W-1:0] o_cross_y,
    output logic                             o_no_crossing,
    output logic                             o_clipped
);

    localparam int DMW = 2 * COORD_BITS + 1;
    localparam int QB  = lip_pkg::QUOT_BITS;

    logic en;

    logic            s_valid [0:QB];
    logic [DMW-1:0]  s_dm    [0:QB];
    logic [DMW-1:0]  s_rem_x [0:QB];
    logic [DMW-1:0]  s_rem_y [0:QB];
    logic [QB-1:0]   s_bits_x[0:QB];
    logic [QB-1:0]   s_bits_y[0:QB];
    lip_pkg::t_flags s_flags [0:QB];

    assign en         = ~o_out_valid | i_out_ready;
    assign o_in_ready = en;

    lip_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_a_start_x(i_a_start_x),
        .i_a_start_y(i_a_start_y),
        .i_a_end_x  (i_a_end_x),
        .i_a_end_y  (i_a_end_y),
        .i_b_start_x(i_b_start_x),
        .i_b_start_y(i_b_start_y),
        .i_b_end_x  (i_b_end_x),
        .i_b_end_y  (i_b_end_y),
        .o_valid    (s_valid[0]),
        .o_dm       (s_dm[0]),
        .o_rem_x    (s_rem_x[0]),
        .o_rem_y    (s_rem_y[0]),
        .o_bits_x   (s_bits_x[0]),
        .o_bits_y   (s_bits_y[0]),
        .o_flags    (s_flags[0])
    );

    for (genvar g = 0; g < QB; g++) begin : g_step
        lip_div_step #(
            .DMW(DMW)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[g]),
            .i_dm    (s_dm[g]),
            .i_rem_x (s_rem_x[g]),
            .i_rem_y (s_rem_y[g]),
            .i_bits_x(s_bits_x[g]),
            .i_bits_y(s_bits_y[g]),
            .i_flags (s_flags[g]),
            .o_valid (s_valid[g+1]),
            .o_dm    (s_dm[g+1]),
            .o_rem_x (s_rem_x[g+1]),
            .o_rem_y (s_rem_y[g+1]),
            .o_bits_x(s_bits_x[g+1]),
            .o_bits_y(s_bits_y[g+1]),
            .o_flags (s_flags[g+1])
        );
    end

    lip_sat u_sat (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (s_valid[QB]),
        .i_quot_x     (s_bits_x[QB]),
        .i_quot_y     (s_bits_y[QB]),
        .i_flags      (s_flags[QB]),
        .o_valid      (o_out_valid),
        .o_cross_x    (o_cross_x),
        .o_cross_y    (o_cross_y),
        .o_no_crossing(o_no_crossing),
        .o_clipped    (o_clipped)
    );

endmodule
